@@ rtl/heightmap_bilinear_sampler_assert.svh @@
// Assertion macros shared by the sampler design.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH

`ifndef ASSERT_OFF

`define HBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/hbs_pkg.sv @@
package hbs_pkg;

    localparam int HEIGHT_W     = 32;
    localparam int POS_W        = 32;
    localparam int TPU_W        = 24;
    localparam int SIZE_W       = 9;
    localparam int TEXEL_W      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int DIFF_W       = POS_W + 1;
    localparam int PROD_W       = DIFF_W + TPU_W + 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 7;

    localparam logic [TPU_W-1:0]  TPU_RESET  = 24'h02_0000;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Z   = 3'd1,
        CFG_TPU_X      = 3'd2,
        CFG_TPU_Z      = 3'd3,
        CFG_MAP_WIDTH  = 3'd4,
        CFG_MAP_HEIGHT = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_z;
        logic [TPU_W-1:0]        tpu_x;
        logic [TPU_W-1:0]        tpu_z;
        logic [SIZE_W-1:0]       map_width;
        logic [SIZE_W-1:0]       map_height;
    } t_cfg;

    typedef struct packed {
        logic                      mode;
        logic [TEXEL_W-1:0]        col;
        logic [TEXEL_W-1:0]        row;
        logic [HEIGHT_W-1:0]       height;
    } t_item;

endpackage

@@ rtl/heightmap_bilinear_sampler.sv @@
// Height map sampler with bilinear filtering and clamping at the map edges.
// The input channel (i_valid, o_stall) takes one word per cycle while o_stall
// is low: mode 0 writes one texel height, mode 1 samples the height at a
// world point. The output channel (o_valid, i_stall) returns exactly one word
// per input word, in order: on_terrain and the interpolated Q16.16 height, or
// zero for a write or a point off the map.
// One word a cycle is sustained while the receiver does not stall, since the
// texel store is split into four banks by column and row parity and the four
// neighbours are read in a single cycle. The configuration port (i_cfg_valid,
// o_cfg_ready) is always ready; the user must write it only while no words
// are in flight, since the block itself does not enforce this.
// Reset clears the pipeline and sets the registers to their defaults; the
// texel store is not cleared and must be written before it is sampled.
// When the receiver stalls, the output word holds, the pipeline fills, and a
// four-word queue between the address front end and the memory back end
// absorbs the slack before o_stall rises.
`include "heightmap_bilinear_sampler_assert.svh"

module heightmap_bilinear_sampler #(
    parameter int MAX_MAP_WIDTH  = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_mode,
    input  logic [hbs_pkg::TEXEL_W-1:0]           i_texel_col,
    input  logic [hbs_pkg::TEXEL_W-1:0]           i_texel_row,
    input  logic signed [hbs_pkg::HEIGHT_W-1:0]   i_texel_height,
    input  logic signed [hbs_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [hbs_pkg::POS_W-1:0]      i_pos_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_on_terrain,
    output logic signed [hbs_pkg::HEIGHT_W-1:0]   o_height,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int CW       = $clog2(MAX_MAP_WIDTH);
    localparam int RW       = $clog2(MAX_MAP_HEIGHT);
    localparam int ENTRY_W  = 2 + 2 * CW + 2 * RW + 2 * FRACTION_BITS + hbs_pkg::HEIGHT_W;
    localparam int CAPACITY = hbs_pkg::FRONT_STAGES + hbs_pkg::QUEUE_DEPTH
                            + hbs_pkg::BACK_STAGES;
    localparam int FLW      = $clog2(CAPACITY + 1) + 1;

    hbs_pkg::t_cfg      r_cfg;
    logic               q_push, q_full, q_valid, q_pop;
    logic [ENTRY_W-1:0] q_in, q_out;
    logic [FLW-1:0]     r_inflight;
    logic               in_acc, out_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= '0;
            r_cfg.origin_z   <= '0;
            r_cfg.tpu_x      <= hbs_pkg::TPU_RESET;
            r_cfg.tpu_z      <= hbs_pkg::TPU_RESET;
            r_cfg.map_width  <= hbs_pkg::SIZE_RESET;
            r_cfg.map_height <= hbs_pkg::SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (hbs_pkg::t_cfg_index'(i_cfg_index))
                hbs_pkg::CFG_ORIGIN_X:   r_cfg.origin_x   <= i_cfg_data;
                hbs_pkg::CFG_ORIGIN_Z:   r_cfg.origin_z   <= i_cfg_data;
                hbs_pkg::CFG_TPU_X:      r_cfg.tpu_x      <= i_cfg_data[hbs_pkg::TPU_W-1:0];
                hbs_pkg::CFG_TPU_Z:      r_cfg.tpu_z      <= i_cfg_data[hbs_pkg::TPU_W-1:0];
                hbs_pkg::CFG_MAP_WIDTH:  r_cfg.map_width  <= i_cfg_data[hbs_pkg::SIZE_W-1:0];
                hbs_pkg::CFG_MAP_HEIGHT: r_cfg.map_height <= i_cfg_data[hbs_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    hbs_front #(
        .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
        .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_texel_col    (i_texel_col),
        .i_texel_row    (i_texel_row),
        .i_texel_height (i_texel_height),
        .i_pos_x        (i_pos_x),
        .i_pos_z        (i_pos_z),
        .o_push         (q_push),
        .i_full         (q_full),
        .o_entry        (q_in)
    );

    hbs_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (hbs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    hbs_back #(
        .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
        .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (q_pop),
        .i_entry      (q_out),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_on_terrain (o_on_terrain),
        .o_height     (o_height)
    );

    // Words accepted but not yet delivered.
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_inflight <= r_inflight + FLW'(1);
                2'b01:   r_inflight <= r_inflight - FLW'(1);
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    `HBS_ASSERT_IMPLIES(a_idle_no_result, i_clk, i_rst_n, r_inflight == '0, !o_valid,
        "result presented with no word in flight")
    `HBS_ASSERT_IMPLIES(a_inflight_bound, i_clk, i_rst_n, 1'b1,
        r_inflight <= FLW'(CAPACITY), "more words in flight than the pipeline holds")
    `HBS_ASSERT_NEXT(a_full_stalls, i_clk, i_rst_n,
        r_inflight == FLW'(CAPACITY) && !out_acc, o_stall,
        "input accepted with the pipeline full")

endmodule

@@ rtl/hbs_front.sv @@
module hbs_front #(
    parameter int MAX_MAP_WIDTH  = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int FRACTION_BITS  = 16,
    localparam int CW      = $clog2(MAX_MAP_WIDTH),
    localparam int RW      = $clog2(MAX_MAP_HEIGHT),
    localparam int ENTRY_W = 2 + 2 * CW + 2 * RW + 2 * FRACTION_BITS + hbs_pkg::HEIGHT_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hbs_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic [hbs_pkg::TEXEL_W-1:0]         i_texel_col,
    input  logic [hbs_pkg::TEXEL_W-1:0]         i_texel_row,
    input  logic signed [hbs_pkg::HEIGHT_W-1:0] i_texel_height,
    input  logic signed [hbs_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [hbs_pkg::POS_W-1:0]    i_pos_z,
    output logic                                o_push,
    input  logic                                i_full,
    output logic [ENTRY_W-1:0]                  o_entry
);

    localparam int TW    = hbs_pkg::PROD_W;
    localparam int DW    = hbs_pkg::DIFF_W;
    localparam int SHIFT = hbs_pkg::POS_W - FRACTION_BITS;
    localparam int SWX   = ($clog2(MAX_MAP_WIDTH + 1) > hbs_pkg::SIZE_W) ?
                           $clog2(MAX_MAP_WIDTH + 1) : hbs_pkg::SIZE_W;
    localparam int SWZ   = ($clog2(MAX_MAP_HEIGHT + 1) > hbs_pkg::SIZE_W) ?
                           $clog2(MAX_MAP_HEIGHT + 1) : hbs_pkg::SIZE_W;
    localparam int CXW   = (CW > hbs_pkg::TEXEL_W) ? CW : hbs_pkg::TEXEL_W;
    localparam int RXW   = (RW > hbs_pkg::TEXEL_W) ? RW : hbs_pkg::TEXEL_W;

    typedef struct packed {
        logic                        we;
        logic                        hit;
        logic [CW-1:0]               cx;
        logic [CW-1:0]               cx1;
        logic [RW-1:0]               rz;
        logic [RW-1:0]               rz1;
        logic [FRACTION_BITS-1:0]    u;
        logic [FRACTION_BITS-1:0]    v;
        logic [hbs_pkg::HEIGHT_W-1:0] data;
    } t_entry;

    logic                 r_va, r_vb, r_vc;
    logic                 en_a, en_b, en_c;
    hbs_pkg::t_item       r_item_a, r_item_b, r_item_c;
    logic signed [DW-1:0] r_dx_a, r_dz_a;
    logic signed [TW-1:0] r_px_b, r_pz_b;
    logic signed [TW-1:0] r_tx_c, r_tz_c;

    logic signed [DW-1:0] n_dx, n_dz;
    logic signed [TW-1:0] n_px, n_pz;
    logic signed [TW-1:0] n_tx, n_tz;
    logic [SWX-1:0]       eff_w;
    logic [SWZ-1:0]       eff_h;
    logic [TW-1:0]        span_x, span_z;
    logic signed [TW-1:0] half_x, half_z;
    logic                 hit_x, hit_z;
    logic [CW-1:0]        idx_x;
    logic [RW-1:0]        idx_z;
    logic                 last_x, last_z;
    logic                 col_ok, row_ok;
    t_entry               entry;

    assign en_c    = !r_vc || !i_full;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_stall = !en_a;
    assign o_push  = r_vc && !i_full;

    // Map sizes of zero act as one and oversize values act as the store size.
    always_comb begin
        if (i_cfg.map_width == '0) begin
            eff_w = SWX'(1);
        end else if (SWX'(i_cfg.map_width) > SWX'(MAX_MAP_WIDTH)) begin
            eff_w = SWX'(MAX_MAP_WIDTH);
        end else begin
            eff_w = SWX'(i_cfg.map_width);
        end
        if (i_cfg.map_height == '0) begin
            eff_h = SWZ'(1);
        end else if (SWZ'(i_cfg.map_height) > SWZ'(MAX_MAP_HEIGHT)) begin
            eff_h = SWZ'(MAX_MAP_HEIGHT);
        end else begin
            eff_h = SWZ'(i_cfg.map_height);
        end
    end

    assign span_x = TW'(eff_w) << FRACTION_BITS;
    assign span_z = TW'(eff_h) << FRACTION_BITS;
    assign half_x = $signed(TW'(eff_w) << (FRACTION_BITS - 1));
    assign half_z = $signed(TW'(eff_h) << (FRACTION_BITS - 1));

    assign n_dx = $signed({i_pos_x[hbs_pkg::POS_W-1], i_pos_x})
                - $signed({i_cfg.origin_x[hbs_pkg::POS_W-1], i_cfg.origin_x});
    assign n_dz = $signed({i_pos_z[hbs_pkg::POS_W-1], i_pos_z})
                - $signed({i_cfg.origin_z[hbs_pkg::POS_W-1], i_cfg.origin_z});

    assign n_px = r_dx_a * $signed({1'b0, i_cfg.tpu_x});
    assign n_pz = r_dz_a * $signed({1'b0, i_cfg.tpu_z});

    assign n_tx = (r_px_b >>> SHIFT) + half_x;
    assign n_tz = (r_pz_b >>> SHIFT) + half_z;

    assign hit_x  = !r_tx_c[TW-1] && ($unsigned(r_tx_c) < span_x);
    assign hit_z  = !r_tz_c[TW-1] && ($unsigned(r_tz_c) < span_z);
    assign idx_x  = r_tx_c[FRACTION_BITS +: CW];
    assign idx_z  = r_tz_c[FRACTION_BITS +: RW];
    assign last_x = ((CW + 1)'(idx_x) + (CW + 1)'(1)) == (CW + 1)'(eff_w);
    assign last_z = ((RW + 1)'(idx_z) + (RW + 1)'(1)) == (RW + 1)'(eff_h);
    assign col_ok = (CXW + 1)'(r_item_c.col) < (CXW + 1)'(MAX_MAP_WIDTH);
    assign row_ok = (RXW + 1)'(r_item_c.row) < (RXW + 1)'(MAX_MAP_HEIGHT);

    always_comb begin
        entry.we   = !r_item_c.mode && col_ok && row_ok;
        entry.hit  = r_item_c.mode && hit_x && hit_z;
        entry.u    = r_tx_c[FRACTION_BITS-1:0];
        entry.v    = r_tz_c[FRACTION_BITS-1:0];
        entry.data = r_item_c.height;
        if (r_item_c.mode) begin
            entry.cx  = idx_x;
            entry.cx1 = last_x ? idx_x : idx_x + CW'(1);
            entry.rz  = idx_z;
            entry.rz1 = last_z ? idx_z : idx_z + RW'(1);
        end else begin
            entry.cx  = CW'(r_item_c.col);
            entry.cx1 = CW'(r_item_c.col);
            entry.rz  = RW'(r_item_c.row);
            entry.rz1 = RW'(r_item_c.row);
        end
    end

    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_item_a <= '{mode: i_mode, col: i_texel_col, row: i_texel_row,
                          height: i_texel_height};
            r_dx_a   <= n_dx;
            r_dz_a   <= n_dz;
        end
        if (en_b) begin
            r_item_b <= r_item_a;
            r_px_b   <= n_px;
            r_pz_b   <= n_pz;
        end
        if (en_c) begin
            r_item_c <= r_item_b;
            r_tx_c   <= n_tx;
            r_tz_c   <= n_tz;
        end
    end

endmodule

@@ rtl/hbs_queue.sv @@
module hbs_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic [PW-1:0]    n_wp, n_rp;
    logic [CNTW-1:0]  n_cnt;

    assign o_full  = r_cnt == CNTW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_buf[r_rp];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNTW'(1);
            2'b01:   n_cnt = r_cnt - CNTW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/hbs_back.sv @@
module hbs_back #(
    parameter int MAX_MAP_WIDTH  = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int FRACTION_BITS  = 16,
    localparam int CW      = $clog2(MAX_MAP_WIDTH),
    localparam int RW      = $clog2(MAX_MAP_HEIGHT),
    localparam int ENTRY_W = 2 + 2 * CW + 2 * RW + 2 * FRACTION_BITS + hbs_pkg::HEIGHT_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_pop,
    input  logic [ENTRY_W-1:0]                  i_entry,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_on_terrain,
    output logic signed [hbs_pkg::HEIGHT_W-1:0] o_height
);

    localparam int HW      = hbs_pkg::HEIGHT_W;
    localparam int DW      = hbs_pkg::DIFF_W;
    localparam int MW      = DW + FRACTION_BITS + 1;
    localparam int SUMW    = HW + 2;
    localparam int CHW     = (CW > 1) ? CW - 1 : 1;
    localparam int RHW     = (RW > 1) ? RW - 1 : 1;
    localparam int BANK_AW = CHW + RHW;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    typedef struct packed {
        logic                     we;
        logic                     hit;
        logic [CW-1:0]            cx;
        logic [CW-1:0]            cx1;
        logic [RW-1:0]            rz;
        logic [RW-1:0]            rz1;
        logic [FRACTION_BITS-1:0] u;
        logic [FRACTION_BITS-1:0] v;
        logic [HW-1:0]            data;
    } t_entry;

    typedef struct packed {
        logic cx0;
        logic cx10;
        logic rz0;
        logic rz10;
    } t_par;

    t_entry e;
    assign e = i_entry;

    logic en_m, en_1, en_2, en_3, en_4, en_5, en_o;
    logic r_vm, r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;

    logic [HW-1:0] r_rd [4];

    logic                     r_hit_m, r_hit_1, r_hit_2, r_hit_3, r_hit_4, r_hit_5;
    t_par                     r_par_m;
    logic [FRACTION_BITS-1:0] r_u_m, r_u_1;
    logic [FRACTION_BITS-1:0] r_v_m, r_v_1, r_v_2, r_v_3, r_v_4;
    logic signed [HW-1:0]     r_h00_1, r_h01_1, r_h00_2, r_h01_2;
    logic signed [DW-1:0]     r_dt_1, r_db_1, r_dv_4;
    logic signed [MW-1:0]     r_pt_2, r_pb_2, r_pv_5;
    logic signed [HW-1:0]     r_top_3, r_bot_3, r_top_4, r_top_5;
    logic                     r_on_o;
    logic signed [HW-1:0]     r_height_o;

    logic signed [HW-1:0]   h00, h10, h01, h11;
    logic signed [DW-1:0]   n_dt, n_db, n_dv;
    logic signed [MW-1:0]   n_pt, n_pb, n_pv;
    logic signed [SUMW-1:0] sum_t, sum_b, sum_r;

    assign en_o  = !r_vo || !i_stall;
    assign en_5  = !r_v5 || en_o;
    assign en_4  = !r_v4 || en_5;
    assign en_3  = !r_v3 || en_4;
    assign en_2  = !r_v2 || en_3;
    assign en_1  = !r_v1 || en_2;
    assign en_m  = !r_vm || en_1;
    assign o_pop = i_valid && en_m;

    // Four banks split by column and row parity, so the four neighbours of a
    // sample always fall in distinct banks, or repeat one when clamped.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PC = 1'(b % 2);
        localparam logic PR = 1'(b / 2);

        logic [HW-1:0]      r_mem [BANK_DEPTH];
        logic [CW-1:0]      col_sel;
        logic [RW-1:0]      row_sel;
        logic [BANK_AW-1:0] addr;
        logic               we;

        always_comb begin
            col_sel = (e.cx[0] == PC) ? e.cx : e.cx1;
            row_sel = (e.rz[0] == PR) ? e.rz : e.rz1;
            addr    = {RHW'(row_sel >> 1), CHW'(col_sel >> 1)};
            we      = i_valid && e.we && (e.cx[0] == PC) && (e.rz[0] == PR);
        end

        always_ff @(posedge i_clk) begin
            if (en_m) begin
                if (we) begin
                    r_mem[addr] <= e.data;
                end
                r_rd[b] <= r_mem[addr];
            end
        end
    end

    always_comb begin
        h00 = r_rd[{r_par_m.rz0,  r_par_m.cx0}];
        h10 = r_rd[{r_par_m.rz0,  r_par_m.cx10}];
        h01 = r_rd[{r_par_m.rz10, r_par_m.cx0}];
        h11 = r_rd[{r_par_m.rz10, r_par_m.cx10}];
        n_dt = DW'(h10) - DW'(h00);
        n_db = DW'(h11) - DW'(h01);
        n_pt = r_dt_1 * $signed({1'b0, r_u_1});
        n_pb = r_db_1 * $signed({1'b0, r_u_1});
        sum_t = SUMW'(r_h00_2) + SUMW'(r_pt_2 >>> FRACTION_BITS);
        sum_b = SUMW'(r_h01_2) + SUMW'(r_pb_2 >>> FRACTION_BITS);
        n_dv = DW'(r_bot_3) - DW'(r_top_3);
        n_pv = r_dv_4 * $signed({1'b0, r_v_4});
        sum_r = SUMW'(r_top_5) + SUMW'(r_pv_5 >>> FRACTION_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_m) begin
                r_vm <= i_valid;
            end
            if (en_1) begin
                r_v1 <= r_vm;
            end
            if (en_2) begin
                r_v2 <= r_v1;
            end
            if (en_3) begin
                r_v3 <= r_v2;
            end
            if (en_4) begin
                r_v4 <= r_v3;
            end
            if (en_5) begin
                r_v5 <= r_v4;
            end
            if (en_o) begin
                r_vo <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_hit_m <= e.hit;
            r_par_m <= '{cx0: e.cx[0], cx10: e.cx1[0], rz0: e.rz[0], rz10: e.rz1[0]};
            r_u_m   <= e.u;
            r_v_m   <= e.v;
        end
        if (en_1) begin
            r_hit_1 <= r_hit_m;
            r_u_1   <= r_u_m;
            r_v_1   <= r_v_m;
            r_h00_1 <= h00;
            r_h01_1 <= h01;
            r_dt_1  <= n_dt;
            r_db_1  <= n_db;
        end
        if (en_2) begin
            r_hit_2 <= r_hit_1;
            r_v_2   <= r_v_1;
            r_h00_2 <= r_h00_1;
            r_h01_2 <= r_h01_1;
            r_pt_2  <= n_pt;
            r_pb_2  <= n_pb;
        end
        if (en_3) begin
            r_hit_3 <= r_hit_2;
            r_v_3   <= r_v_2;
            r_top_3 <= sum_t[HW-1:0];
            r_bot_3 <= sum_b[HW-1:0];
        end
        if (en_4) begin
            r_hit_4 <= r_hit_3;
            r_v_4   <= r_v_3;
            r_top_4 <= r_top_3;
            r_dv_4  <= n_dv;
        end
        if (en_5) begin
            r_hit_5 <= r_hit_4;
            r_top_5 <= r_top_4;
            r_pv_5  <= n_pv;
        end
        if (en_o) begin
            r_on_o     <= r_hit_5;
            r_height_o <= r_hit_5 ? sum_r[HW-1:0] : '0;
        end
    end

    assign o_valid      = r_vo;
    assign o_on_terrain = r_on_o;
    assign o_height     = r_height_o;

endmodule
